FILE: hw/rtl/wci_pkg.sv
// shared types, constants and fixed-point helpers of the wake convolution core
package wci_pkg;

   localparam int BINS       = 256;
   localparam int WAKE_DEPTH = 1024;
   localparam int FRAC_BITS  = 16;

   localparam int BIN_AW  = $clog2(BINS);
   localparam int WAKE_AW = $clog2(WAKE_DEPTH);
   localparam int BCNT_W  = $clog2(BINS + 1);
   localparam int WCNT_W  = $clog2(WAKE_DEPTH + 1);
   localparam int Z_W     = BIN_AW + 33;
   localparam int DD_W    = Z_W + 1;
   localparam int DIV_N   = (DD_W > 32 + FRAC_BITS) ? DD_W : 32 + FRAC_BITS;
   localparam int DEN_W   = 33;
   localparam int SQ_W    = DIV_N + (DIV_N % 2);
   localparam int RT_W    = SQ_W / 2;
   localparam int K_W     = RT_W + 2;
   localparam int TERMS   = 5;
   localparam int TERM_W  = 3;

   localparam logic [TERM_W-1:0] TERM_XLEAD  = 3'd0;
   localparam logic [TERM_W-1:0] TERM_XTRAIL = 3'd1;
   localparam logic [TERM_W-1:0] TERM_YLEAD  = 3'd2;
   localparam logic [TERM_W-1:0] TERM_YTRAIL = 3'd3;
   localparam logic [TERM_W-1:0] TERM_LONG   = 3'd4;

   localparam logic [1:0] CMD_LOAD_BIN  = 2'd0;
   localparam logic [1:0] CMD_LOAD_WAKE = 2'd1;
   localparam logic [1:0] CMD_COMPUTE   = 2'd2;

   localparam logic [2:0] REG_BINS_IN_USE      = 3'd0;
   localparam logic [2:0] REG_WAKE_POINTS      = 3'd1;
   localparam logic [2:0] REG_CELL_SIZE        = 3'd2;
   localparam logic [2:0] REG_PARTICLE_WEIGHT  = 3'd3;
   localparam logic [2:0] REG_GRID_STEP        = 3'd4;
   localparam logic [2:0] REG_GRID_START_Z     = 3'd5;
   localparam logic [2:0] REG_GRID_START_INDEX = 3'd6;

   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         index;
      logic signed [31:0] bin_density;
      logic signed [31:0] bin_xmom;
      logic signed [31:0] bin_ymom;
      logic signed [31:0] wake_coord;
      logic signed [31:0] wake_long;
      logic signed [31:0] wake_x_lead;
      logic signed [31:0] wake_x_trail;
      logic signed [31:0] wake_y_lead;
      logic signed [31:0] wake_y_trail;
   } req_type;

   typedef struct packed {
      logic [7:0]         target_bin;
      logic signed [63:0] x_lead_sum;
      logic signed [63:0] x_trail_sum;
      logic signed [63:0] y_lead_sum;
      logic signed [63:0] y_trail_sum;
      logic signed [63:0] long_sum;
   } rsp_type;

   typedef struct packed {
      logic [8:0]         bins_in_use;
      logic [10:0]        wake_points;
      logic [30:0]        cell_size;
      logic [30:0]        particle_weight;
      logic [30:0]        grid_step;
      logic signed [31:0] grid_start_z;
      logic signed [11:0] grid_start_index;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD_BIN, OP_LOAD_WAKE, OP_INIT, OP_ZMUL, OP_ZCHK, OP_SQRT_GO,
      OP_KCHK, OP_RDA, OP_RDB, OP_RDC, OP_SPAN, OP_TSET, OP_BASE, OP_BASEW,
      OP_BMX, OP_BMXW, OP_BMY, OP_BMYW, OP_TD, OP_TV, OP_TP, OP_TA, OP_NEXT
   } op_type;

   typedef struct packed {
      logic tgt_ok;
      logic skip_z;
      logic div_done;
      logic sqrt_done;
      logic skip_k;
      logic span_zero;
      logic term_last;
      logic bin_last;
   } dp_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > MAX32) r = 32'sh7FFFFFFF;
      else if (v < MIN32) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   // product shifted down with floor rounding, then clamped
   function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
      return sat32(p >>> FRAC_BITS);
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
      logic signed [64:0] s;
      logic signed [63:0] r;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else r = s[63:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/wci_ram.sv
// generic simple dual-port ram with registered read
module wci_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   assign rdata = rd_ff;
endmodule

FILE: hw/rtl/wci_div.sv
// restoring unsigned divider, one quotient bit per cycle
module wci_div import wci_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_N-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [DIV_N-1:0] quo,
   output logic             done
);
   localparam int CNT_W = $clog2(DIV_N + 1);

   logic [DIV_N-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   rem_sh;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      rem_sh  = {rem_ff, num_ff[DIV_N-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         quo_in  = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIV_N);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[DIV_N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule

FILE: hw/rtl/wci_sqrt.sv
// integer square root, one root bit per cycle
module wci_sqrt import wci_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [SQ_W-1:0] n,
   output logic [RT_W-1:0] root,
   output logic            done
);
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [SQ_W-1:0] n_ff, n_in;
   logic [RT_W-1:0] root_ff, root_in;
   logic [RT_W+2:0] rem_ff, rem_in, rem_sh, trial;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      n_in    = n_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      rem_sh  = {rem_ff[RT_W:0], n_ff[SQ_W-1:SQ_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         n_in    = n;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = CNT_W'(RT_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         n_in = n_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      n_ff    <= n_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign root = root_ff;
   assign done = done_ff;
endmodule

FILE: hw/rtl/wci_dp.sv
// datapath: stores, shared multiplier, divider, square root and sums
module wci_dp import wci_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  op_type     op,
   input  req_type    req,
   input  cfg_type    cfg,
   output dp_sts_type sts,
   output rsp_type    rsp
);
   logic [BCNT_W-1:0] nb;
   logic [WCNT_W-1:0] nw;
   logic [DEN_W-1:0]  dz;

   // stores
   logic               bin_we, wake_we;
   logic [BIN_AW-1:0]  bin_waddr;
   logic [WAKE_AW-1:0] wake_waddr, wake_raddr;
   logic [31:0]        bin_wd [3];
   logic [31:0]        bin_rd [3];
   logic [31:0]        wake_wd [TERMS+1];
   logic [31:0]        wake_rd [TERMS+1];

   logic [BIN_AW-1:0]        i_ff, j_ff;
   logic [7:0]               tgt_ff;
   logic signed [Z_W-1:0]    z_ff;
   logic                     zneg_ff, tneg_ff;
   logic signed [K_W-1:0]    kz_ff;
   logic signed [31:0]       t_ff, dens_ff, xm_ff, ym_ff, base_ff, bmx_ff, bmy_ff, v_ff;
   logic signed [31:0]       coord0_ff, clo_ff, chi_ff;
   logic signed [31:0]       wlo_ff [TERMS];
   logic signed [31:0]       whi_ff [TERMS];
   logic signed [63:0]       prod_ff;
   logic [TERM_W-1:0]        term_ff;
   logic signed [63:0]       sum_ff [TERMS];

   logic signed [Z_W-1:0]    z_now;
   logic signed [DD_W-1:0]   dd;
   logic [DD_W-1:0]          dd_mag;
   logic signed [K_W-1:0]    root_s, st_s, nw_s, kz_calc;
   logic signed [32:0]       c_span, z1x;
   logic [32:0]              span_mag, z1_mag;
   logic signed [31:0]       z1, lo_t, hi_t, d_t, t_calc, v_calc;
   logic signed [63:0]       q64;
   logic signed [BIN_AW:0]   jmi;
   logic signed [32:0]       mul_a, mul_b;
   logic signed [65:0]       mul_p;
   logic                     is_lead;

   logic             div_start, div_done, sqrt_start, sqrt_done;
   logic [DIV_N-1:0] div_num, div_quo;
   logic [DEN_W-1:0] div_den;
   logic [RT_W-1:0]  root;

   always_comb begin
      nb = (32'(cfg.bins_in_use) > 32'(BINS)) ? BCNT_W'(BINS) : BCNT_W'(cfg.bins_in_use);
      nw = (32'(cfg.wake_points) > 32'(WAKE_DEPTH)) ? WCNT_W'(WAKE_DEPTH)
                                                    : WCNT_W'(cfg.wake_points);
      dz = (cfg.grid_step == '0) ? DEN_W'(1) : DEN_W'(cfg.grid_step);
   end

   assign bin_we     = (op == OP_LOAD_BIN) && (32'(req.index) < 32'(BINS));
   assign wake_we    = (op == OP_LOAD_WAKE) && (32'(req.index) < 32'(WAKE_DEPTH));
   assign bin_waddr  = BIN_AW'(req.index);
   assign wake_waddr = WAKE_AW'(req.index);
   assign wake_raddr = (op == OP_RDB) ? WAKE_AW'(kz_ff + 1'b1) : WAKE_AW'(kz_ff);
   assign bin_wd[0]  = req.bin_density;
   assign bin_wd[1]  = req.bin_xmom;
   assign bin_wd[2]  = req.bin_ymom;
   assign wake_wd[TERM_XLEAD]  = req.wake_x_lead;
   assign wake_wd[TERM_XTRAIL] = req.wake_x_trail;
   assign wake_wd[TERM_YLEAD]  = req.wake_y_lead;
   assign wake_wd[TERM_YTRAIL] = req.wake_y_trail;
   assign wake_wd[TERM_LONG]   = req.wake_long;
   assign wake_wd[TERMS]       = req.wake_coord;

   for (genvar g = 0; g < 3; g++) begin : g_bin
      wci_ram #(.WIDTH(32), .DEPTH(BINS)) u_ram (
         .clock(clock), .we(bin_we), .waddr(bin_waddr), .wdata(bin_wd[g]),
         .raddr(j_ff), .rdata(bin_rd[g])
      );
   end

   for (genvar g = 0; g < TERMS + 1; g++) begin : g_wake
      wci_ram #(.WIDTH(32), .DEPTH(WAKE_DEPTH)) u_ram (
         .clock(clock), .we(wake_we), .waddr(wake_waddr), .wdata(wake_wd[g]),
         .raddr(wake_raddr), .rdata(wake_rd[g])
      );
   end

   // distance, grid index and interpolation fraction
   always_comb begin
      z_now   = prod_ff[Z_W-1:0];
      dd      = DD_W'(z_now) - DD_W'(cfg.grid_start_z);
      dd_mag  = dd[DD_W-1] ? DD_W'(-dd) : DD_W'(dd);
      root_s  = K_W'({1'b0, root});
      st_s    = K_W'(cfg.grid_start_index);
      nw_s    = K_W'({1'b0, nw});
      kz_calc = zneg_ff ? (st_s - root_s) : (st_s + root_s);
      c_span  = 33'(chi_ff) - 33'(clo_ff);
      span_mag = c_span[32] ? 33'(-c_span) : 33'(c_span);
      z1      = sat32(64'(z_ff) - 64'(clo_ff));
      z1x     = 33'(z1);
      z1_mag  = z1x[32] ? 33'(-z1x) : 33'(z1x);
      q64     = 64'({1'b0, div_quo});
      t_calc  = sat32(tneg_ff ? -q64 : q64);
      lo_t    = wlo_ff[term_ff];
      hi_t    = whi_ff[term_ff];
      d_t     = sat32(64'(hi_t) - 64'(lo_t));
      v_calc  = sat32(64'(lo_t) + 64'(qsat(prod_ff)));
      jmi     = $signed({1'b0, j_ff}) - $signed({1'b0, i_ff});
      is_lead = (term_ff == TERM_XLEAD) || (term_ff == TERM_YLEAD);
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = DIV_N'(dd_mag);
      div_den   = dz;
      if (op == OP_ZCHK) begin
         div_start = !sts.skip_z;
      end else if (op == OP_SPAN) begin
         div_start = !sts.span_zero;
         div_num   = DIV_N'(z1_mag[31:0]) << FRAC_BITS;
         div_den   = span_mag;
      end
   end

   assign sqrt_start = (op == OP_SQRT_GO);

   wci_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .quo(div_quo), .done(div_done)
   );

   wci_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .n(SQ_W'(div_quo)),
      .root(root), .done(sqrt_done)
   );

   // shared multiplier, product registered every cycle
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (op)
         OP_ZMUL: begin
            mul_a = 33'(jmi);
            mul_b = {2'b00, cfg.cell_size};
         end
         OP_BASE: begin
            mul_a = 33'(dens_ff);
            mul_b = {2'b00, cfg.particle_weight};
         end
         OP_BMX: begin
            mul_a = 33'(base_ff);
            mul_b = 33'(xm_ff);
         end
         OP_BMY: begin
            mul_a = 33'(base_ff);
            mul_b = 33'(ym_ff);
         end
         OP_TD: begin
            mul_a = 33'(d_t);
            mul_b = 33'(t_ff);
         end
         OP_TP: begin
            mul_a = is_lead ? ((term_ff == TERM_XLEAD) ? 33'(bmx_ff) : 33'(bmy_ff))
                            : 33'(base_ff);
            mul_b = 33'(v_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      sts.tgt_ok    = 32'(req.index) < 32'(nb);
      sts.skip_z    = 64'(z_now) < 64'(coord0_ff);
      sts.div_done  = div_done;
      sts.sqrt_done = sqrt_done;
      sts.skip_k    = (kz_calc < 0) || ((kz_calc + 1'b1) >= nw_s);
      sts.span_zero = (c_span == '0);
      sts.term_last = (term_ff == TERM_LONG);
      sts.bin_last  = (BCNT_W'(j_ff) == nb - 1'b1);
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p[63:0];
      if (wake_we && (req.index == '0)) begin
         coord0_ff <= req.wake_coord;
      end
      unique case (op)
         OP_INIT: begin
            i_ff   <= BIN_AW'(req.index);
            tgt_ff <= req.index[7:0];
            j_ff   <= '0;
            for (int k = 0; k < TERMS; k++) begin
               sum_ff[k] <= '0;
            end
         end
         OP_ZCHK: begin
            z_ff    <= z_now;
            zneg_ff <= dd[DD_W-1];
            dens_ff <= bin_rd[0];
            xm_ff   <= bin_rd[1];
            ym_ff   <= bin_rd[2];
         end
         OP_KCHK: kz_ff <= kz_calc;
         OP_RDB: begin
            clo_ff <= wake_rd[TERMS];
            for (int k = 0; k < TERMS; k++) begin
               wlo_ff[k] <= wake_rd[k];
            end
         end
         OP_RDC: begin
            chi_ff <= wake_rd[TERMS];
            for (int k = 0; k < TERMS; k++) begin
               whi_ff[k] <= wake_rd[k];
            end
         end
         OP_SPAN: begin
            tneg_ff <= z1x[32] ^ c_span[32];
            t_ff    <= '0;
         end
         OP_TSET: t_ff <= t_calc;
         OP_BASEW: begin
            base_ff <= qsat(prod_ff);
            term_ff <= TERM_XLEAD;
         end
         OP_BMXW: bmx_ff <= qsat(prod_ff);
         OP_BMYW: bmy_ff <= qsat(prod_ff);
         OP_TV: v_ff <= v_calc;
         OP_TA: begin
            sum_ff[term_ff] <= sat_add64(sum_ff[term_ff], prod_ff);
            term_ff         <= term_ff + 1'b1;
         end
         OP_NEXT: j_ff <= j_ff + 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.target_bin  = tgt_ff;
      rsp.x_lead_sum  = sum_ff[TERM_XLEAD];
      rsp.x_trail_sum = sum_ff[TERM_XTRAIL];
      rsp.y_lead_sum  = sum_ff[TERM_YLEAD];
      rsp.y_trail_sum = sum_ff[TERM_YTRAIL];
      rsp.long_sum    = sum_ff[TERM_LONG];
   end
endmodule

FILE: hw/rtl/wci_ctrl.sv
// controller state machine sequencing loads and the per-bin walk
module wci_ctrl import wci_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] command,
   input  dp_sts_type sts,
   output op_type     op,
   output logic       busy,
   output logic       rsp_valid
);
   typedef enum logic [24:0] {
      S_IDLE   = 25'h0000001,
      S_ZMUL   = 25'h0000002,
      S_ZCHK   = 25'h0000004,
      S_DIV1   = 25'h0000008,
      S_SQRTGO = 25'h0000010,
      S_SQRT   = 25'h0000020,
      S_KCHK   = 25'h0000040,
      S_RDA    = 25'h0000080,
      S_RDB    = 25'h0000100,
      S_RDC    = 25'h0000200,
      S_SPAN   = 25'h0000400,
      S_DIV2   = 25'h0000800,
      S_TSET   = 25'h0001000,
      S_BASE   = 25'h0002000,
      S_BASEW  = 25'h0004000,
      S_BMX    = 25'h0008000,
      S_BMXW   = 25'h0010000,
      S_BMY    = 25'h0020000,
      S_BMYW   = 25'h0040000,
      S_TD     = 25'h0080000,
      S_TV     = 25'h0100000,
      S_TP     = 25'h0200000,
      S_TA     = 25'h0400000,
      S_NEXT   = 25'h0800000,
      S_DONE   = 25'h1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               priority if (command == CMD_LOAD_BIN) begin
                  op = OP_LOAD_BIN;
               end else if (command == CMD_LOAD_WAKE) begin
                  op = OP_LOAD_WAKE;
               end else if ((command == CMD_COMPUTE) && sts.tgt_ok) begin
                  op       = OP_INIT;
                  state_in = S_ZMUL;
               end else begin
                  op = OP_NONE;
               end
            end
         end
         S_ZMUL: begin
            op       = OP_ZMUL;
            state_in = S_ZCHK;
         end
         S_ZCHK: begin
            op       = OP_ZCHK;
            state_in = sts.skip_z ? S_NEXT : S_DIV1;
         end
         S_DIV1: if (sts.div_done) state_in = S_SQRTGO;
         S_SQRTGO: begin
            op       = OP_SQRT_GO;
            state_in = S_SQRT;
         end
         S_SQRT: if (sts.sqrt_done) state_in = S_KCHK;
         S_KCHK: begin
            op       = OP_KCHK;
            state_in = sts.skip_k ? S_NEXT : S_RDA;
         end
         S_RDA: begin
            op       = OP_RDA;
            state_in = S_RDB;
         end
         S_RDB: begin
            op       = OP_RDB;
            state_in = S_RDC;
         end
         S_RDC: begin
            op       = OP_RDC;
            state_in = S_SPAN;
         end
         S_SPAN: begin
            op       = OP_SPAN;
            state_in = sts.span_zero ? S_BASE : S_DIV2;
         end
         S_DIV2: if (sts.div_done) state_in = S_TSET;
         S_TSET: begin
            op       = OP_TSET;
            state_in = S_BASE;
         end
         S_BASE: begin
            op       = OP_BASE;
            state_in = S_BASEW;
         end
         S_BASEW: begin
            op       = OP_BASEW;
            state_in = S_BMX;
         end
         S_BMX: begin
            op       = OP_BMX;
            state_in = S_BMXW;
         end
         S_BMXW: begin
            op       = OP_BMXW;
            state_in = S_BMY;
         end
         S_BMY: begin
            op       = OP_BMY;
            state_in = S_BMYW;
         end
         S_BMYW: begin
            op       = OP_BMYW;
            state_in = S_TD;
         end
         S_TD: begin
            op       = OP_TD;
            state_in = S_TV;
         end
         S_TV: begin
            op       = OP_TV;
            state_in = S_TP;
         end
         S_TP: begin
            op       = OP_TP;
            state_in = S_TA;
         end
         S_TA: begin
            op       = OP_TA;
            state_in = sts.term_last ? S_NEXT : S_TD;
         end
         S_NEXT: begin
            op       = OP_NEXT;
            state_in = sts.bin_last ? S_DONE : S_ZMUL;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
endmodule

FILE: hw/rtl/wake_convolution_interpolated_core.sv
// top level of the interpolated wakefield convolution core
//
//  channel   ports                      direction  transfer
//  request   start busy req_payload     in         start high while busy low
//  response  rsp_valid rsp_payload      out        one-cycle strobe, no back-pressure
//  config    psel penable pwrite paddr  in/out     apb write on access phase, pready tied high
//
// load transactions (bin or wake point) finish in the accept cycle; busy never rises
// a compute transaction holds busy for the whole walk over bins_in_use source bins
// a bin that passes both range checks is paced by the shared bit-serial divider, used twice,
// and the bit-serial square root; equal neighbouring coordinates skip the second division;
// a bin cut by the distance check skips the divider and the square root, one cut by the
// grid index check skips the second division and the interpolation
// reset is synchronous, loads the config register defaults and clears the sequencer; stores are
// undefined until loaded; the response side cannot stall, so the result is shown once
module wake_convolution_interpolated_core import wci_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   cfg_type    cfg_ff, cfg_in;
   dp_sts_type sts;
   op_type     op;
   logic       csr_wr;
   logic [2:0] csr_idx;

   // configuration registers, written on the apb access phase
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_BINS_IN_USE:      cfg_in.bins_in_use      = pwdata[8:0];
            REG_WAKE_POINTS:      cfg_in.wake_points      = pwdata[10:0];
            REG_CELL_SIZE:        cfg_in.cell_size        = pwdata[30:0];
            REG_PARTICLE_WEIGHT:  cfg_in.particle_weight  = pwdata[30:0];
            REG_GRID_STEP:        cfg_in.grid_step        = pwdata[30:0];
            REG_GRID_START_Z:     cfg_in.grid_start_z     = pwdata;
            REG_GRID_START_INDEX: cfg_in.grid_start_index = pwdata[11:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bins_in_use      <= 9'd256;
         cfg_ff.wake_points      <= 11'd1024;
         cfg_ff.cell_size        <= 31'd65536;
         cfg_ff.particle_weight  <= 31'd65536;
         cfg_ff.grid_step        <= 31'd65536;
         cfg_ff.grid_start_z     <= '0;
         cfg_ff.grid_start_index <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_BINS_IN_USE:      prdata = 32'(cfg_ff.bins_in_use);
         REG_WAKE_POINTS:      prdata = 32'(cfg_ff.wake_points);
         REG_CELL_SIZE:        prdata = 32'(cfg_ff.cell_size);
         REG_PARTICLE_WEIGHT:  prdata = 32'(cfg_ff.particle_weight);
         REG_GRID_STEP:        prdata = 32'(cfg_ff.grid_step);
         REG_GRID_START_Z:     prdata = cfg_ff.grid_start_z;
         REG_GRID_START_INDEX: prdata = 32'({cfg_ff.grid_start_index});
         default:              prdata = '0;
      endcase
   end

   // sequencer: decodes each transaction and steps the datapath
   wci_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .command(req_payload.command),
      .sts(sts), .op(op), .busy(busy), .rsp_valid(rsp_valid)
   );

   // datapath: stores, multiplier, divider, square root, accumulators
   wci_dp u_dp (
      .clock(clock), .reset(reset), .op(op), .req(req_payload), .cfg(cfg_ff),
      .sts(sts), .rsp(rsp_payload)
   );

   // a result ends the compute transaction
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy still high after result");

   // a result only comes out of a running compute transaction
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // a load never occupies the core
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.command != CMD_COMPUTE)) |=> !busy)
      else $error("load transaction raised busy");

   // results never come in consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
endmodule

FILE: verif/wake_sum_checker.sv
// checker that mirrors the wake convolution core and compares its results
module wake_sum_checker import wci_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_payload,
   input  logic        rsp_valid,
   input  rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          errors,
   output int          pending
);

   localparam longint LMAX = 64'sh7FFFFFFFFFFFFFFF;
   localparam longint LMIN = 64'sh8000000000000000;

   longint bins_reg, points_reg, cell_reg, weight_reg, step_reg, zstart_reg, kstart_reg;

   longint density_m[BINS], xmean_m[BINS], ymean_m[BINS];
   longint coord_m[WAKE_DEPTH], long_m[WAKE_DEPTH];
   longint xlead_m[WAKE_DEPTH], xtrail_m[WAKE_DEPTH];
   longint ylead_m[WAKE_DEPTH], ytrail_m[WAKE_DEPTH];

   rsp_type sums_due[$];

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // exact product, floor shift, clamp
   function automatic longint qprod(input longint a, input longint b);
      return clamp32((a * b) >>> FRAC_BITS);
   endfunction

   function automatic longint addsat(input longint a, input longint b);
      if (b > 0 && a > LMAX - b) return LMAX;
      if (b < 0 && a < LMIN - b) return LMIN;
      return a + b;
   endfunction

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic longint lerp(input longint a, input longint b, input longint t);
      return clamp32(a + qprod(clamp32(b - a), t));
   endfunction

   // one target bin: walk all source bins in use and accumulate five sums
   function automatic bit wake_sums(input logic [9:0] tgt, output rsp_type r);
      longint nb, nw, i, zs, dz, st, z, kz, z1, span, t, base;
      longint unsigned s;
      longint acc[5];
      nb = (bins_reg > BINS) ? BINS : bins_reg;
      nw = (points_reg > WAKE_DEPTH) ? WAKE_DEPTH : points_reg;
      i = longint'(tgt);
      r = '0;
      if (i >= nb) return 0;
      zs = zstart_reg;
      dz = (step_reg != 0) ? step_reg : 1;
      st = kstart_reg;
      for (int k = 0; k < 5; k++) acc[k] = 0;
      for (longint j = 0; j < nb; j++) begin
         z = (j - i) * cell_reg;
         if (z < coord_m[0]) continue;
         if (z >= zs) begin
            s = root64(longint'(z - zs) / dz);
            kz = st + longint'(s);
         end else begin
            s = root64(longint'(zs - z) / dz);
            kz = st - longint'(s);
         end
         if (kz < 0 || kz + 1 >= nw) continue;
         z1 = clamp32(z - coord_m[kz]);
         span = coord_m[kz+1] - coord_m[kz];
         t = (span != 0) ? clamp32((z1 <<< FRAC_BITS) / span) : 0;
         base = qprod(density_m[j], weight_reg);
         acc[0] = addsat(acc[0], qprod(base, xmean_m[j]) * lerp(xlead_m[kz], xlead_m[kz+1], t));
         acc[1] = addsat(acc[1], base * lerp(xtrail_m[kz], xtrail_m[kz+1], t));
         acc[2] = addsat(acc[2], qprod(base, ymean_m[j]) * lerp(ylead_m[kz], ylead_m[kz+1], t));
         acc[3] = addsat(acc[3], base * lerp(ytrail_m[kz], ytrail_m[kz+1], t));
         acc[4] = addsat(acc[4], base * lerp(long_m[kz], long_m[kz+1], t));
      end
      r.target_bin  = tgt[7:0];
      r.x_lead_sum  = acc[0];
      r.x_trail_sum = acc[1];
      r.y_lead_sum  = acc[2];
      r.y_trail_sum = acc[3];
      r.long_sum    = acc[4];
      return 1;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
      for (int k = 0; k < BINS; k++) begin
         density_m[k] = 0; xmean_m[k] = 0; ymean_m[k] = 0;
      end
      for (int k = 0; k < WAKE_DEPTH; k++) begin
         coord_m[k] = 0; long_m[k] = 0; xlead_m[k] = 0;
         xtrail_m[k] = 0; ylead_m[k] = 0; ytrail_m[k] = 0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         bins_reg = 256; points_reg = 1024; cell_reg = 65536; weight_reg = 65536;
         step_reg = 65536; zstart_reg = 0; kstart_reg = 0;
         sums_due.delete();
      end else begin
         if (rsp_valid) begin
            got = rsp_payload;
            if (sums_due.size() == 0) begin
               $error("result for bin %0d with none expected", got.target_bin);
               errors++;
            end else begin
               want = sums_due.pop_front();
               if (got.target_bin !== want.target_bin) begin
                  $error("target_bin expected %0d got %0d", want.target_bin, got.target_bin);
                  errors++;
               end
               if (got.x_lead_sum !== want.x_lead_sum) begin
                  $error("x_lead_sum expected %0d got %0d", want.x_lead_sum, got.x_lead_sum);
                  errors++;
               end
               if (got.x_trail_sum !== want.x_trail_sum) begin
                  $error("x_trail_sum expected %0d got %0d", want.x_trail_sum, got.x_trail_sum);
                  errors++;
               end
               if (got.y_lead_sum !== want.y_lead_sum) begin
                  $error("y_lead_sum expected %0d got %0d", want.y_lead_sum, got.y_lead_sum);
                  errors++;
               end
               if (got.y_trail_sum !== want.y_trail_sum) begin
                  $error("y_trail_sum expected %0d got %0d", want.y_trail_sum, got.y_trail_sum);
                  errors++;
               end
               if (got.long_sum !== want.long_sum) begin
                  $error("long_sum expected %0d got %0d", want.long_sum, got.long_sum);
                  errors++;
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_BINS_IN_USE:      bins_reg = longint'(pwdata[8:0]);
               REG_WAKE_POINTS:      points_reg = longint'(pwdata[10:0]);
               REG_CELL_SIZE:        cell_reg = longint'(pwdata[30:0]);
               REG_PARTICLE_WEIGHT:  weight_reg = longint'(pwdata[30:0]);
               REG_GRID_STEP:        step_reg = longint'(pwdata[30:0]);
               REG_GRID_START_Z:     zstart_reg = longint'($signed(pwdata));
               REG_GRID_START_INDEX: kstart_reg = longint'($signed(pwdata[11:0]));
               default: ;
            endcase
         end
         if (start && !busy) begin
            case (req_payload.command)
               CMD_LOAD_BIN: if (req_payload.index < BINS) begin
                  density_m[req_payload.index] = req_payload.bin_density;
                  xmean_m[req_payload.index]   = req_payload.bin_xmom;
                  ymean_m[req_payload.index]   = req_payload.bin_ymom;
               end
               CMD_LOAD_WAKE: begin
                  coord_m[req_payload.index]  = req_payload.wake_coord;
                  long_m[req_payload.index]   = req_payload.wake_long;
                  xlead_m[req_payload.index]  = req_payload.wake_x_lead;
                  xtrail_m[req_payload.index] = req_payload.wake_x_trail;
                  ylead_m[req_payload.index]  = req_payload.wake_y_lead;
                  ytrail_m[req_payload.index] = req_payload.wake_y_trail;
               end
               CMD_COMPUTE: if (wake_sums(req_payload.index, want)) sums_due.push_back(want);
               default: ;
            endcase
         end
      end
      pending = sums_due.size();
   end

endmodule

FILE: verif/testbench.sv
// stimulus and verdict for the wake convolution core
module testbench;
   import wci_pkg::*;

   // cycles with no transaction before the run is declared hung
   localparam int HANG_LIMIT  = 400000;
   localparam int ITEM_TARGET = 1450;
   localparam int TAIL_ITEMS  = 150;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int errors;
   int pending;
   int items_sent;
   int quiet_cycles;
   bit no_gaps;

   // which store entries hold data, so no unwritten entry is ever read
   bit bin_loaded[BINS];
   bit wake_loaded[WAKE_DEPTH];
   int live_bins;
   int live_points;
   longint live_step;

   wake_convolution_interpolated_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   wake_sum_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hang watchdog: any accepted transaction or result restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // apb write: setup cycle then access cycle
   task automatic reg_write(input logic [2:0] which, input logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = {which, 2'b00}; pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   // present one transaction and hold it until the core takes it
   task automatic send(input req_type p);
      @(negedge clock);
      start = 1'b1;
      req_payload = p;
      do @(posedge clock); while (busy);
      items_sent++;
      if (p.command == CMD_LOAD_BIN && p.index < BINS) bin_loaded[p.index] = 1'b1;
      if (p.command == CMD_LOAD_WAKE) wake_loaded[p.index] = 1'b1;
   endtask

   task automatic pause(input int n);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // drain: all results in, core idle, then a margin before touching registers
   task automatic drain();
      pause(1);
      while (pending != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      endcase
   endfunction

   // random fields everywhere so every payload bit moves
   function automatic req_type noise_item(input logic [1:0] cmd, input logic [9:0] idx);
      req_type p;
      logic [351:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
      p = noise[$bits(req_type)-1:0];
      p.command = cmd;
      p.index = idx;
      return p;
   endfunction

   task automatic load_bin(input logic [9:0] idx);
      req_type p;
      p = noise_item(CMD_LOAD_BIN, idx);
      p.bin_density = pick_value();
      p.bin_xmom = pick_value();
      p.bin_ymom = pick_value();
      send(p);
   endtask

   // mostly quadratic, monotone coordinates so the grid lookup lands somewhere useful
   task automatic load_wake(input logic [9:0] idx);
      req_type p;
      longint c;
      p = noise_item(CMD_LOAD_WAKE, idx);
      if ($urandom_range(0, 3) != 0) begin
         c = longint'(idx) * longint'(idx) * live_step + longint'($urandom_range(0, 3));
         if (c > 64'sd2147483647) c = 64'sd2147483647;
         p.wake_coord = c[31:0];
      end
      p.wake_long = pick_value();
      p.wake_x_lead = pick_value();
      p.wake_x_trail = pick_value();
      p.wake_y_lead = pick_value();
      p.wake_y_trail = pick_value();
      send(p);
   endtask

   // load every entry a compute may read under the current sizes
   task automatic fill_stores();
      for (int k = 0; k < live_bins; k++) if (!bin_loaded[k]) load_bin(10'(k));
      for (int k = 0; k < live_points; k++) if (!wake_loaded[k]) load_wake(10'(k));
   endtask

   task automatic setup(input int nb_raw, input int nw_raw, input logic [31:0] bin_width,
                        input logic [31:0] weight, input logic [31:0] step,
                        input logic [31:0] zstart, input logic [31:0] kstart);
      drain();
      reg_write(REG_BINS_IN_USE, 32'(nb_raw));
      reg_write(REG_WAKE_POINTS, 32'(nw_raw));
      reg_write(REG_CELL_SIZE, bin_width);
      reg_write(REG_PARTICLE_WEIGHT, weight);
      reg_write(REG_GRID_STEP, step);
      reg_write(REG_GRID_START_Z, zstart);
      reg_write(REG_GRID_START_INDEX, kstart);
      live_bins = (nb_raw > BINS) ? BINS : nb_raw;
      live_points = (nw_raw > WAKE_DEPTH) ? WAKE_DEPTH : nw_raw;
      live_step = (step[30:0] == 0) ? 1 : longint'(step[30:0]);
      fill_stores();
   endtask

   function automatic logic [31:0] pick_size();
      case ($urandom_range(0, 5))
         0: return 32'd1;
         1: return 32'h7FFFFFFF;
         2: return $urandom_range(1, 1 << 20);
         default: return 32'd65536;
      endcase
   endfunction

   // one random configuration; big selects the full-depth extremes
   task automatic random_setup(input int big);
      int nb, nw;
      logic [31:0] step, kstart, zstart;
      nb = $urandom_range(1, 8);
      nw = $urandom_range(2, 16);
      if ($urandom_range(0, 5) == 0) nb = 1;
      if ($urandom_range(0, 5) == 0) nw = 2;
      if (big == 1) nb = 511;                    // above depth, clamps to all bins
      if (big == 2) nw = 2047;                   // above depth, clamps to full table
      step = ($urandom_range(0, 7) == 0) ? 32'd0 : pick_size();
      case ($urandom_range(0, 4))
         0: kstart = -32'sd1024;
         1: kstart = 32'd1024;
         2: kstart = 32'($urandom_range(0, 12)) - 32'd4;
         default: kstart = 32'd0;
      endcase
      case ($urandom_range(0, 3))
         0: zstart = $urandom;
         1: zstart = 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         default: zstart = 32'd0;
      endcase
      setup(nb, nw, pick_size(),
            ($urandom_range(0, 5) == 0) ? 32'd0 : pick_size(), step, zstart, kstart);
   endtask

   // one random transaction; loads mostly touch what a compute may later read
   task automatic random_item();
      int sel;
      logic [9:0] idx;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, live_bins - 1));
         load_bin(idx);
      end else if (sel < 62) begin
         idx = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                          : 10'($urandom_range(0, live_points - 1));
         load_wake(idx);
      end else if (sel < 95) begin
         idx = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, live_bins));
         send(noise_item(CMD_COMPUTE, idx));
      end else begin
         send(noise_item(CMD_UNKNOWN, 10'($urandom)));
      end
   endtask

   initial begin
      req_type p;
      int phase_items;
      int phase_no;
      int big;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      items_sent = 0;
      no_gaps = 1'b0;
      live_step = 65536;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: four bins, four points, unit grid
      setup(4, 4, 32'd65536, 32'd65536, 32'd65536, 32'd0, 32'd0);
      p = noise_item(CMD_LOAD_BIN, 10'd0);
      p.bin_density = 32'h7FFFFFFF; p.bin_xmom = 32'h7FFFFFFF; p.bin_ymom = 32'h7FFFFFFF;
      send(p);
      p = noise_item(CMD_LOAD_BIN, 10'd1);
      p.bin_density = 32'h80000000; p.bin_xmom = 32'h80000000; p.bin_ymom = 32'h7FFFFFFF;
      send(p);
      p = noise_item(CMD_LOAD_BIN, 10'd2);
      p.bin_density = 32'd0;
      send(p);
      load_bin(10'd1023);                        // out of range bin, dropped
      // equal neighbouring coordinates at the table start
      p = noise_item(CMD_LOAD_WAKE, 10'd0);
      p.wake_coord = 32'd0; p.wake_long = 32'h7FFFFFFF; p.wake_x_lead = 32'h80000000;
      send(p);
      p = noise_item(CMD_LOAD_WAKE, 10'd1);
      p.wake_coord = 32'd0; p.wake_long = 32'h80000000; p.wake_x_lead = 32'h7FFFFFFF;
      send(p);
      p = noise_item(CMD_LOAD_WAKE, 10'd2);
      p.wake_coord = 32'h00040000;
      send(p);
      p = noise_item(CMD_LOAD_WAKE, 10'd3);
      p.wake_coord = 32'h00090000;
      send(p);
      load_wake(10'd1023);
      send(noise_item(CMD_UNKNOWN, 10'd2));      // unknown command
      for (int t = 0; t < 5; t++) send(noise_item(CMD_COMPUTE, 10'(t)));
      send(noise_item(CMD_COMPUTE, 10'd1023));   // target beyond bins in use
      // zero grid step, negative start index and a far origin
      setup(4, 4, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd0, 32'h80000000, 32'hFFFFFC00);
      for (int t = 0; t < 4; t++) send(noise_item(CMD_COMPUTE, 10'(t)));
      setup(1, 2, 32'd1, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd1024);
      send(noise_item(CMD_COMPUTE, 10'd0));

      // random phases; the sender also waits for every result at each boundary
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         big = (phase_no == 1) ? 1 : (phase_no == 3) ? 2 : 0;
         random_setup(big);
         // all-bin walks are slow, so keep that phase short
         phase_items = (big == 1) ? 6 : $urandom_range(30, 80);
         for (int n = 0; n < phase_items && items_sent < ITEM_TARGET; n++) begin
            no_gaps = (items_sent >= ITEM_TARGET - TAIL_ITEMS);
            if (!no_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
            random_item();
         end
         phase_no++;
      end

      pause(1);
      while (pending != 0 || busy) @(negedge clock);
      repeat (16) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
